FILE: design/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg: shared types and constants of the interval set tracker
// Table sizes, coordinate type, request and status codes, and the command and
// status words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ist_pkg;

  localparam int MAX_INTERVALS = 64;
  localparam int COORD_BITS    = 32;
  localparam int IDX_W         = $clog2(MAX_INTERVALS);
  localparam int COUNT_W       = $clog2(MAX_INTERVALS + 1);
  // write count may pass the capacity by one before the overflow check
  localparam int WCNT_W        = $clog2(MAX_INTERVALS + 2);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [WCNT_W-1:0]     wcnt_t;

  typedef struct packed {
    coord_t lo;
    coord_t hi;
  } span_t;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic load_req;
    logic rd_en;
    logic proc;
    logic proc2;
    logic tail;
    logic finish;
  } ist_cmd_t;

  typedef struct packed {
    logic skip;
    logic empty;
    logic need2;
    logic last;
  } ist_stat_t;

endpackage

FILE: design/ist_if.sv
// ----------------------------------------------------------------------------
// ist_if: request and response channels of the interval set tracker
// Valid/ready channels; a word moves on an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface ist_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  ist_pkg::coord_t   range_start;
  ist_pkg::coord_t   range_end;

  modport source (output valid, req_type, range_start, range_end, input ready);
  modport sink   (input valid, req_type, range_start, range_end, output ready);
endinterface

interface ist_rsp_if;
  logic              valid;
  logic              ready;
  logic              covered;
  logic [1:0]        status;
  ist_pkg::count_t   interval_count;

  modport source (output valid, covered, status, interval_count, input ready);
  modport sink   (input valid, covered, status, interval_count, output ready);
endinterface

FILE: design/ist_ctrl.sv
// ----------------------------------------------------------------------------
// ist_ctrl: request sequencer
// Walks the stored table at most once per request and hands the result word to the
// output register when that is free.
// ----------------------------------------------------------------------------
module ist_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output ist_pkg::ist_cmd_t   cmd,
  input  ist_pkg::ist_stat_t  stat
);
  import ist_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_PROC   = 6'b000100,
    S_PROC2  = 6'b001000,
    S_TAIL   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.skip) begin
          state_next = S_DONE;
        end else if (stat.empty) begin
          state_next = S_TAIL;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_PROC;
        end
      end
      S_PROC: begin
        cmd.proc = 1'b1;
        if (stat.need2) begin
          state_next = S_PROC2;
        end else if (stat.last) begin
          state_next = S_TAIL;
        end else begin
          // next entry read overlaps this one's processing
          cmd.rd_en = 1'b1;
        end
      end
      S_PROC2: begin
        cmd.proc2 = 1'b1;
        if (stat.last) begin
          state_next = S_TAIL;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_PROC;
        end
      end
      S_TAIL: begin
        cmd.tail   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/ist_datapath.sv
// ----------------------------------------------------------------------------
// ist_datapath: interval table and rebuild logic
// Two table banks in one memory; a rebuild reads the live bank and writes the
// other, which becomes live only when the new table fits.
// ----------------------------------------------------------------------------
module ist_datapath (
  input  logic                clk,
  input  logic                rst,
  input  ist_pkg::ist_cmd_t   cmd,
  output ist_pkg::ist_stat_t  stat,
  input  logic [1:0]          in_type,
  input  ist_pkg::coord_t     in_start,
  input  ist_pkg::coord_t     in_end,
  output logic                out_covered,
  output logic [1:0]          out_status,
  output ist_pkg::count_t     out_count
);
  import ist_pkg::*;

  localparam int DEPTH = 2 ** (IDX_W + 1);

  span_t     mem [DEPTH];
  span_t     rd_data;
  span_t     pend;
  req_kind_t kind;
  coord_t    req_lo;
  coord_t    req_hi;
  logic      placed;
  logic      cov;
  wcnt_t     wcnt;
  count_t    rd_idx;
  count_t    count;
  logic      bank;

  logic      kept;
  logic      place;
  logic      w1;
  logic      w2;
  span_t     o1;
  span_t     o2;
  logic      tail_wr;
  logic      wr_req;
  logic      wr_en;
  span_t     wr_data;
  logic      bad;
  logic      walk;
  logic      fits;
  logic      commit;
  count_t    count_next;
  status_t   status_next;

  assign kept  = (rd_data.hi < req_lo) || (rd_data.lo > req_hi);
  assign place = (kind == REQ_ADD) && (rd_data.lo > req_hi) && !placed;

  // up to two output intervals for each stored one
  always_comb begin
    w1 = 1'b0;
    w2 = 1'b0;
    o1 = rd_data;
    o2 = rd_data;
    case (kind)
      REQ_ADD: begin
        if (place) begin
          w1 = 1'b1;
          w2 = 1'b1;
          o1 = {req_lo, req_hi};
        end else if (kept) begin
          w1 = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (kept) begin
          w1 = 1'b1;
        end else if (rd_data.lo < req_lo) begin
          w1 = 1'b1;
          o1 = {rd_data.lo, req_lo};
          if (rd_data.hi > req_hi) begin
            w2 = 1'b1;
            o2 = {req_hi, rd_data.hi};
          end
        end else if (rd_data.hi > req_hi) begin
          w1 = 1'b1;
          o1 = {req_hi, rd_data.hi};
        end
      end
      default: begin
        w1 = 1'b0;
      end
    endcase
  end

  assign tail_wr = cmd.tail && (kind == REQ_ADD) && !placed;
  assign wr_req  = (cmd.proc && w1) || cmd.proc2 || tail_wr;
  assign wr_en   = wr_req && (wcnt < WCNT_W'(MAX_INTERVALS));
  assign wr_data = cmd.proc2 ? pend : (cmd.proc ? o1 : {req_lo, req_hi});

  assign bad    = (req_lo >= req_hi);
  assign walk   = ((kind == REQ_ADD) || (kind == REQ_REMOVE)) && !bad;
  assign fits   = (wcnt <= WCNT_W'(MAX_INTERVALS));
  assign commit = walk && fits;
  assign count_next = commit ? count_t'(wcnt) : count;

  always_comb begin
    if (kind == REQ_NONE) begin
      status_next = ST_OK;
    end else if (bad) begin
      status_next = ST_RANGE;
    end else if (walk && !fits) begin
      status_next = ST_FULL;
    end else begin
      status_next = ST_OK;
    end
  end

  assign stat.skip  = (kind == REQ_NONE) || bad;
  assign stat.empty = (count == '0);
  assign stat.need2 = w2;
  assign stat.last  = (rd_idx == count);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[{bank, rd_idx[IDX_W-1:0]}];
    end
    if (wr_en) begin
      mem[{~bank, wcnt[IDX_W-1:0]}] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind   <= req_kind_t'(in_type);
      req_lo <= in_start;
      req_hi <= in_end;
    end else if (cmd.proc && (kind == REQ_ADD) && !kept) begin
      // absorb an overlapping or touching interval
      if (rd_data.lo < req_lo) begin
        req_lo <= rd_data.lo;
      end
      if (rd_data.hi > req_hi) begin
        req_hi <= rd_data.hi;
      end
    end
    if (cmd.proc) begin
      pend <= o2;
    end
    if (cmd.finish) begin
      out_covered <= (kind == REQ_QUERY) && !bad && cov;
      out_status  <= status_next;
      out_count   <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      placed <= 1'b0;
      cov    <= 1'b0;
      wcnt   <= '0;
      rd_idx <= '0;
      count  <= '0;
      bank   <= 1'b0;
    end else begin
      if (cmd.load_req) begin
        placed <= 1'b0;
        cov    <= 1'b0;
        wcnt   <= '0;
        rd_idx <= '0;
      end else begin
        if (cmd.rd_en) begin
          rd_idx <= rd_idx + 1'b1;
        end
        if (wr_req) begin
          wcnt <= wcnt + 1'b1;
        end
        if (cmd.proc && place) begin
          placed <= 1'b1;
        end
        if (cmd.proc && (kind == REQ_QUERY) &&
            (rd_data.lo <= req_lo) && (rd_data.hi >= req_hi)) begin
          cov <= 1'b1;
        end
      end
      if (cmd.finish) begin
        count <= count_next;
        bank  <= bank ^ commit;
      end
    end
  end

endmodule

FILE: design/interval_set_tracker.sv
// ----------------------------------------------------------------------------
// interval_set_tracker: sorted table of disjoint half-open intervals
// Add merges, remove clips or splits, query checks full coverage; every
// request returns one response word with coverage, status and count.
//
//   channel   dir   word fields
//   req       in    req_type, range_start, range_end
//   rsp       out   covered, status, interval_count
//
// one request at a time; add, remove and query walk the table at one entry
// a cycle through the memory read port, save that an entry that gives two
// intervals (split or insert ahead) holds the walk in a second write state
// unused request kinds and empty ranges skip the walk, from decode to done
// rst is synchronous and empties the table; no clearing pass is needed
// a stalled response holds in its register while the next request is taken
// ----------------------------------------------------------------------------
module interval_set_tracker (
  input logic       clk,
  input logic       rst,
  ist_req_if.sink   req,
  ist_rsp_if.source rsp
);
  import ist_pkg::*;

  ist_cmd_t  cmd;
  ist_stat_t stat;

  ist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  ist_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_type     (req.req_type),
    .in_start    (req.range_start),
    .in_end      (req.range_end),
    .out_covered (rsp.covered),
    .out_status  (rsp.status),
    .out_count   (rsp.interval_count)
  );

endmodule

FILE: design/ist_checker.sv
// ----------------------------------------------------------------------------
// ist_checker: port-level checks on the interval set tracker
// Watches the request and response channels and flags behaviour the block
// should never show.
// ----------------------------------------------------------------------------
module ist_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input logic            rsp_covered,
  input logic [1:0]      rsp_status,
  input ist_pkg::count_t rsp_count
);
  import ist_pkg::*;

  // one request in flight: no new word straight after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while previous one still in work");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_count <= COUNT_W'(MAX_INTERVALS)))
    else $error("interval count beyond table capacity");

  a_cov_only_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status != ST_OK)) |-> !rsp_covered)
    else $error("coverage flagged on a failed request");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_covered) && $stable(rsp_status) && $stable(rsp_count)))
    else $error("stalled response word changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid straight after reset");

endmodule

bind interval_set_tracker ist_checker u_ist_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_covered (rsp.covered),
  .rsp_status  (rsp.status),
  .rsp_count   (rsp.interval_count)
);
